FILE: sv/psn_pkg.sv
package psn_pkg;

    localparam logic [7:0] SLASH_CH = 8'h2F;
    localparam logic [7:0] DOT_CH   = 8'h2E;

    localparam int MAX_RES = 4;
    localparam int RES_IW  = $clog2(MAX_RES);
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam int QDEPTH  = 8;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int QCW     = $clog2(QDEPTH + 1);

    localparam logic [1:0] WC_NONE = 2'd0;
    localparam logic [1:0] WC_MANY = 2'd2;

    typedef enum logic [1:0] {
        LK_NONE     = 2'd0,
        LK_SLASH    = 2'd1,
        LK_SLASHDOT = 2'd2,
        LK_LEADDOT  = 2'd3
    } lk_t;

    typedef struct packed {
        logic [1:0] wclass;
        logic       slash_due;
        lk_t        kind;
        logic [7:0] held;
        logic       held_valid;
    } state_t;

    localparam state_t ST_RESET = '{
        wclass: WC_NONE,
        slash_due: 1'b0,
        kind: LK_NONE,
        held: 8'd0,
        held_valid: 1'b0
    };

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } res_t;

    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        res_t [MAX_RES-1:0]         res;
    } push_t;

    typedef struct packed {
        state_t                     st;
        logic [CNT_W-1:0]           cnt;
        res_t [MAX_RES-1:0]         res;
    } work_t;

    function automatic work_t emit(work_t w, logic [7:0] b, logic last);
        work_t r;
        r = w;
        if (r.cnt < CNT_W'(MAX_RES))
        begin
            r.res[r.cnt[RES_IW-1:0]].data = b;
            r.res[r.cnt[RES_IW-1:0]].last = last;
            r.cnt = r.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic work_t push_tail(work_t w, logic [7:0] b);
        work_t r;
        r = w;
        if (r.st.held_valid)
        begin
            r = emit(r, r.st.held, 1'b0);
        end
        r.st.held = b;
        r.st.held_valid = 1'b1;
        return r;
    endfunction

    function automatic work_t write_byte(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        if (r.st.wclass < WC_MANY)
        begin
            r.st.wclass = r.st.wclass + 2'd1;
        end
        if (r.st.slash_due)
        begin
            r = push_tail(r, SLASH_CH);
        end
        if (c == SLASH_CH)
        begin
            r.st.slash_due = 1'b1;
        end
        else
        begin
            r.st.slash_due = 1'b0;
            r = push_tail(r, c);
        end
        return r;
    endfunction

    function automatic work_t take_fresh(work_t w, logic [7:0] c);
        work_t r;
        r = w;
        if (c == SLASH_CH)
        begin
            if (!(r.st.slash_due && r.st.wclass == WC_MANY))
            begin
                r.st.kind = LK_SLASH;
            end
        end
        else if (c == DOT_CH && r.st.wclass == WC_NONE)
        begin
            r.st.kind = LK_LEADDOT;
        end
        else
        begin
            r = write_byte(r, c);
        end
        return r;
    endfunction

    function automatic work_t finish_path(work_t w);
        work_t r;
        r = w;
        if (r.st.kind == LK_SLASH)
        begin
            r = write_byte(r, SLASH_CH);
        end
        r.st.kind = LK_NONE;
        if (r.st.slash_due && r.st.wclass < WC_MANY)
        begin
            r = push_tail(r, SLASH_CH);
        end
        if (r.st.held_valid)
        begin
            r = emit(r, r.st.held, 1'b1);
        end
        else
        begin
            r = emit(r, DOT_CH, 1'b1);
        end
        r.st = ST_RESET;
        return r;
    endfunction

    function automatic work_t step(state_t st, logic [7:0] c, logic fin, logic empty);
        work_t w;
        lk_t   kind;
        w.st  = st;
        w.cnt = '0;
        w.res = '0;
        if (empty)
        begin
            w = finish_path(w);
        end
        else
        begin
            kind = w.st.kind;
            w.st.kind = LK_NONE;
            case (kind)
                LK_SLASH:
                begin
                    if (c == DOT_CH)
                    begin
                        w.st.kind = LK_SLASHDOT;
                    end
                    else
                    begin
                        w = write_byte(w, SLASH_CH);
                        w = take_fresh(w, c);
                    end
                end
                LK_SLASHDOT:
                begin
                    if (c != SLASH_CH)
                    begin
                        w = write_byte(w, SLASH_CH);
                        w = write_byte(w, DOT_CH);
                    end
                    w = take_fresh(w, c);
                end
                LK_LEADDOT:
                begin
                    if (c != SLASH_CH)
                    begin
                        w = write_byte(w, DOT_CH);
                        w = take_fresh(w, c);
                    end
                end
                default:
                begin
                    w = take_fresh(w, c);
                end
            endcase
            if (fin)
            begin
                w = finish_path(w);
            end
        end
        return w;
    endfunction

endpackage

FILE: sv/psn_step.sv
module psn_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  logic                in_empty,
    input  logic                space_ok,
    output psn_pkg::push_t      push
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             in_empty_reg;
    psn_pkg::state_t  state_reg;
    psn_pkg::state_t  state_next;
    psn_pkg::work_t   work;
    logic             step_go;

    assign step_go  = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || space_ok;

    always_comb
    begin
        work = psn_pkg::step(state_reg, in_byte_reg, in_last_reg, in_empty_reg);
        state_next = step_go ? work.st : state_reg;
        push.res = work.res;
        push.cnt = step_go ? work.cnt : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= psn_pkg::ST_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg  <= in_byte;
            in_last_reg  <= in_last;
            in_empty_reg <= in_empty;
        end
    end

endmodule

FILE: sv/psn_queue.sv
module psn_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  psn_pkg::push_t      push,
    output logic                space_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    psn_pkg::res_t                  entry_reg [psn_pkg::QDEPTH];
    logic [psn_pkg::QAW-1:0]        wr_ptr_reg;
    logic [psn_pkg::QAW-1:0]        rd_ptr_reg;
    logic [psn_pkg::QCW-1:0]        count_reg;
    logic [psn_pkg::QCW-1:0]        count_next;
    logic                           out_valid_reg;
    psn_pkg::res_t                  out_reg;
    logic                           pop;

    assign space_ok  = count_reg <= psn_pkg::QCW'(psn_pkg::QDEPTH - psn_pkg::MAX_RES);
    assign pop       = (count_reg != '0) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_reg.data;
    assign out_last  = out_reg.last;

    always_comb
    begin
        count_next = count_reg + psn_pkg::QCW'(push.cnt) - psn_pkg::QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + psn_pkg::QAW'(push.cnt);
            count_reg  <= count_next;
            if (pop)
            begin
                rd_ptr_reg    <= rd_ptr_reg + psn_pkg::QAW'(1);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < psn_pkg::MAX_RES; i++)
        begin
            if (psn_pkg::CNT_W'(i) < push.cnt)
            begin
                entry_reg[wr_ptr_reg + psn_pkg::QAW'(i)] <= push.res[i];
            end
        end
        if (pop)
        begin
            out_reg <= entry_reg[rd_ptr_reg];
        end
    end

endmodule

FILE: sv/path_string_normalizer.sv
// path: a result byte passes the input register, a queue entry and the output register
// throughput: one input byte per cycle, set by the combinational step logic; input
// stalls while the result queue has fewer than four free entries
// output: an eight-entry queue and an output register give one byte per cycle while ready
// reset: rst_n is asynchronous, active low; it clears the path state and empties the queue
module path_string_normalizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // path_byte
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // empty_path
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // norm_byte
    output logic        m_axis_tlast
);

    psn_pkg::push_t push;
    logic           space_ok;

    psn_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .in_empty (s_axis_tuser),
        .space_ok (space_ok),
        .push     (push)
    );

    psn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic       is_last;
        logic [7:0] ch;
    } norm_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // path_byte
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;   // empty_path
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // norm_byte
    logic        m_axis_tlast;

    norm_char_t  norm_q[$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;

    // predictor state
    logic [1:0]   out_count = psn_pkg::WC_NONE;
    logic         slash_owed = 1'b0;
    psn_pkg::lk_t la_kind = psn_pkg::LK_NONE;
    logic [7:0]   tail_byte = 8'd0;
    logic         tail_full = 1'b0;
    int           step_emits = 0;

    path_string_normalizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void put_norm(logic [7:0] b, logic is_last);
        if (step_emits < psn_pkg::MAX_RES)
        begin
            norm_q.push_back('{is_last: is_last, ch: b});
            step_emits++;
        end
    endfunction

    function automatic void shift_tail(logic [7:0] b);
        if (tail_full)
        begin
            put_norm(tail_byte, 1'b0);
        end
        tail_byte = b;
        tail_full = 1'b1;
    endfunction

    function automatic void commit_char(logic [7:0] c);
        if (out_count < psn_pkg::WC_MANY)
        begin
            out_count = out_count + 2'd1;
        end
        if (slash_owed)
        begin
            shift_tail(psn_pkg::SLASH_CH);
        end
        if (c == psn_pkg::SLASH_CH)
        begin
            slash_owed = 1'b1;
        end
        else
        begin
            slash_owed = 1'b0;
            shift_tail(c);
        end
    endfunction

    function automatic void absorb_char(logic [7:0] c);
        if (c == psn_pkg::SLASH_CH)
        begin
            // repeated slash once two bytes are out
            if (!(slash_owed && out_count == psn_pkg::WC_MANY))
            begin
                la_kind = psn_pkg::LK_SLASH;
            end
        end
        else if (c == psn_pkg::DOT_CH && out_count == psn_pkg::WC_NONE)
        begin
            la_kind = psn_pkg::LK_LEADDOT;
        end
        else
        begin
            commit_char(c);
        end
    endfunction

    function automatic void close_path();
        if (la_kind == psn_pkg::LK_SLASH)
        begin
            commit_char(psn_pkg::SLASH_CH);
        end
        la_kind = psn_pkg::LK_NONE;
        // trailing slash survives only as the root
        if (slash_owed && out_count < psn_pkg::WC_MANY)
        begin
            shift_tail(psn_pkg::SLASH_CH);
        end
        if (tail_full)
        begin
            put_norm(tail_byte, 1'b1);
        end
        else
        begin
            put_norm(psn_pkg::DOT_CH, 1'b1);
        end
        out_count = psn_pkg::WC_NONE;
        slash_owed = 1'b0;
        tail_byte = 8'd0;
        tail_full = 1'b0;
    endfunction

    function automatic void predict_norm(logic [7:0] c, logic fin, logic empty);
        psn_pkg::lk_t prior;
        step_emits = 0;
        if (empty)
        begin
            close_path();
        end
        else
        begin
            prior = la_kind;
            la_kind = psn_pkg::LK_NONE;
            case (prior)
                psn_pkg::LK_SLASH:
                begin
                    if (c == psn_pkg::DOT_CH)
                    begin
                        la_kind = psn_pkg::LK_SLASHDOT;
                    end
                    else
                    begin
                        commit_char(psn_pkg::SLASH_CH);
                        absorb_char(c);
                    end
                end
                psn_pkg::LK_SLASHDOT:
                begin
                    if (c != psn_pkg::SLASH_CH)
                    begin
                        commit_char(psn_pkg::SLASH_CH);
                        commit_char(psn_pkg::DOT_CH);
                    end
                    absorb_char(c);
                end
                psn_pkg::LK_LEADDOT:
                begin
                    if (c != psn_pkg::SLASH_CH)
                    begin
                        commit_char(psn_pkg::DOT_CH);
                        absorb_char(c);
                    end
                end
                default:
                begin
                    absorb_char(c);
                end
            endcase
            if (fin)
            begin
                close_path();
            end
        end
    endfunction

    // output side: random stall and compare against the oldest expected byte
    always @(posedge clk)
    begin
        norm_char_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (norm_q.size() == 0)
            begin
                $display("%0t unexpected transaction: actual byte %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end
            else
            begin
                want = norm_q.pop_front();
                if (m_axis_tdata !== want.ch)
                begin
                    $display("%0t norm_byte: expected %h actual %h",
                             $time, want.ch, m_axis_tdata);
                    mismatch_count++;
                end
                if (m_axis_tlast !== want.is_last)
                begin
                    $display("%0t norm_last: expected %b actual %b",
                             $time, want.is_last, m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_char(logic [7:0] c, logic fin, logic empty);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        s_axis_tuser  <= empty;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_norm(c, fin, empty);
    endtask

    task automatic send_empty_mark();
        send_char(8'($urandom), 1'($urandom), 1'b1);
    endtask

    task automatic send_str(string s, bit closed);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], closed && (i == s.len() - 1), 1'b0);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (norm_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_path_char();
        int r;
        r = $urandom_range(99);
        if (r < 35)
        begin
            return psn_pkg::SLASH_CH;
        end
        else if (r < 63)
        begin
            return psn_pkg::DOT_CH;
        end
        else if (r < 90)
        begin
            return 8'("a") + 8'($urandom_range(25));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_empty_mark();
        send_str("/.", 1'b1);
        send_str("//a//", 1'b1);
        send_str("./", 1'b0);
        send_char(8'h00, 1'b1, 1'b0);
        send_char(8'hFF, 1'b0, 1'b0);
        send_str("/./.", 1'b1);
        send_str(".", 1'b1);
        send_str("/", 1'b1);
        // path cut short by an empty mark
        send_str("ab", 1'b0);
        send_empty_mark();
        send_str("..", 1'b1);
        wait_drained();
    endtask

    task automatic test_random_stream(int n_items, int idle_pct, int stall_pct);
        int sent;
        int len;
        int mode;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            mode = $urandom_range(99);
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            if (mode < 6)
            begin
                send_empty_mark();
                sent++;
            end
            else
            begin
                for (int i = 0; i < len; i++)
                begin
                    send_char(pick_path_char(), (mode >= 12) && (i == len - 1), 1'b0);
                end
                sent += len;
                if (mode < 12)
                begin
                    send_empty_mark();
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 0;
        recv_stall_pct = 30;
        send_str("/a/b/", 1'b0);
        wait_drained();
        send_str("/.c//", 1'b1);
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_stream(32, 0, 0);
        test_random_stream(32, 75, 0);
        test_random_stream(32, 0, 75);
        test_random_stream(32, 15, 15);
        test_drain_pause();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && norm_q.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
sv/psn_pkg.sv
sv/psn_step.sv
sv/psn_queue.sv
sv/path_string_normalizer.sv
tb/sv/tb.sv
